[rtl/nsc_pkg.sv]
// nsc_pkg: shared constants and helpers for the nmea sentence checker
// character codes, offset limit and hex digit decoding; no dependencies
`default_nettype none

package nsc_pkg;

    // bit widths of the byte, offset and nibble fields
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned OFFSET_W = 7;
    localparam int unsigned NIBBLE_W = 4;

    // latest offset from the dollar sign at which the star may stand
    localparam logic [OFFSET_W-1:0] MAX_STAR_OFFSET = 7'd81;

    // header layout: five letters, then the comma at offset six
    localparam logic [OFFSET_W-1:0] HEAD_LETTERS = 7'd5;
    localparam logic [OFFSET_W-1:0] COMMA_OFFSET = 7'd6;

    // character codes
    localparam logic [BYTE_W-1:0] CH_DOLLAR    = 8'h24;
    localparam logic [BYTE_W-1:0] CH_STAR      = 8'h2a;
    localparam logic [BYTE_W-1:0] CH_COMMA     = 8'h2c;
    localparam logic [BYTE_W-1:0] CH_CR        = 8'h0d;
    localparam logic [BYTE_W-1:0] CH_LF        = 8'h0a;
    localparam logic [BYTE_W-1:0] CH_PRINT_LO  = 8'h20;
    localparam logic [BYTE_W-1:0] CH_PRINT_HI  = 8'h7e;
    localparam logic [BYTE_W-1:0] CH_UPPER_A   = 8'h41;
    localparam logic [BYTE_W-1:0] CH_UPPER_F   = 8'h46;
    localparam logic [BYTE_W-1:0] CH_UPPER_Z   = 8'h5a;
    localparam logic [BYTE_W-1:0] CH_LOWER_A   = 8'h61;
    localparam logic [BYTE_W-1:0] CH_LOWER_F   = 8'h66;
    localparam logic [BYTE_W-1:0] CH_DIGIT_0   = 8'h30;
    localparam logic [BYTE_W-1:0] CH_DIGIT_9   = 8'h39;

    // decoded hex digit with a valid flag
    typedef struct packed {
        logic                valid;
        logic [NIBBLE_W-1:0] value;
    } hex_digit_t;

    // value of an ascii hex digit in either case
    function automatic hex_digit_t hex_decode(input logic [BYTE_W-1:0] c);
        hex_digit_t d;
        logic [BYTE_W-1:0] diff;
        d    = '0;
        diff = '0;
        if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9)
        begin
            diff    = c - CH_DIGIT_0;
            d.valid = 1'b1;
            d.value = diff[NIBBLE_W-1:0];
        end
        else if (c >= CH_UPPER_A && c <= CH_UPPER_F)
        begin
            diff    = c - CH_UPPER_A + 8'd10;
            d.valid = 1'b1;
            d.value = diff[NIBBLE_W-1:0];
        end
        else if (c >= CH_LOWER_A && c <= CH_LOWER_F)
        begin
            diff    = c - CH_LOWER_A + 8'd10;
            d.valid = 1'b1;
            d.value = diff[NIBBLE_W-1:0];
        end
        return d;
    endfunction

endpackage

`default_nettype wire

[rtl/nmea_sentence_checker_unit.sv]
// nmea_sentence_checker_unit: byte stream nmea 0183 sentence checker
// depends on nsc_pkg for character codes and hex decoding
// An input beat goes through the input register, then the result register.
// Throughput: one byte per cycle if unstalled; the input register and the
// result register each advance whenever the stage after them is free or
// being drained. Reset (rst_n low, asynchronous): both registers empty,
// match state in search, checksum and offset zero, found flag clear.
`default_nettype none

module nmea_sentence_checker_unit (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      s_axis_tvalid,
    output logic                           s_axis_tready,
    input  wire logic [nsc_pkg::BYTE_W-1:0] s_axis_tdata,  // [7:0] byte_in
    input  wire logic                      s_axis_tlast,   // buffer_end
    output logic                           m_axis_tvalid,
    input  wire logic                      m_axis_tready,
    output logic [7:0]                     m_axis_tdata    // [0] sentence_ok,
                                                           // [1] any_found
);
    import nsc_pkg::*;

    typedef enum logic [2:0] {
        PH_SEARCH = 3'd0,
        PH_HEAD   = 3'd1,
        PH_BODY   = 3'd2,
        PH_HEX_HI = 3'd3,
        PH_HEX_LO = 3'd4,
        PH_CR     = 3'd5,
        PH_LF     = 3'd6
    } phase_t;

    // input register
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_last_reg;

    // result register
    logic              out_valid_reg;
    logic              out_ok_reg;
    logic              out_found_reg;

    // match state
    phase_t              phase_reg, phase_next;
    logic [OFFSET_W-1:0] offset_reg, offset_next;
    logic [BYTE_W-1:0]   xor_reg, xor_next;
    logic [NIBBLE_W-1:0] nibble_reg, nibble_next;
    logic                found_reg, found_next;

    logic                advance;
    logic                out_free;
    logic [OFFSET_W-1:0] offset_inc;
    logic                hit;
    logic                found_now;
    hex_digit_t          hex;

    // pipeline handshake
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || advance;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_found_reg, out_ok_reg};

    assign offset_inc = offset_reg + 7'd1;
    assign hex        = hex_decode(in_byte_reg);

    // per-byte match update
    always_comb
    begin
        phase_next  = phase_reg;
        offset_next = offset_reg;
        xor_next    = xor_reg;
        nibble_next = nibble_reg;
        hit         = 1'b0;
        if (in_byte_reg == CH_DOLLAR)
        begin
            phase_next  = PH_HEAD;
            offset_next = '0;
            xor_next    = '0;
            nibble_next = '0;
        end
        else
        begin
            // default abandons; arms that keep the candidate override
            phase_next  = PH_SEARCH;
            offset_next = '0;
            xor_next    = '0;
            nibble_next = '0;
            case (phase_reg)
                PH_HEAD:
                begin
                    if (offset_inc <= HEAD_LETTERS && in_byte_reg >= CH_UPPER_A
                        && in_byte_reg <= CH_UPPER_Z)
                    begin
                        phase_next  = PH_HEAD;
                        offset_next = offset_inc;
                        xor_next    = xor_reg ^ in_byte_reg;
                    end
                    else if (offset_inc == COMMA_OFFSET && in_byte_reg == CH_COMMA)
                    begin
                        phase_next  = PH_BODY;
                        offset_next = offset_inc;
                        xor_next    = xor_reg ^ in_byte_reg;
                    end
                end
                PH_BODY:
                begin
                    if (in_byte_reg == CH_STAR)
                    begin
                        if (offset_inc <= MAX_STAR_OFFSET)
                        begin
                            phase_next  = PH_HEX_HI;
                            offset_next = offset_reg;
                            xor_next    = xor_reg;
                        end
                    end
                    else if (in_byte_reg >= CH_PRINT_LO && in_byte_reg <= CH_PRINT_HI
                             && offset_inc < MAX_STAR_OFFSET)
                    begin
                        phase_next  = PH_BODY;
                        offset_next = offset_inc;
                        xor_next    = xor_reg ^ in_byte_reg;
                    end
                end
                PH_HEX_HI:
                begin
                    if (hex.valid)
                    begin
                        phase_next  = PH_HEX_LO;
                        offset_next = offset_reg;
                        xor_next    = xor_reg;
                        nibble_next = hex.value;
                    end
                end
                PH_HEX_LO:
                begin
                    if (hex.valid && xor_reg == {nibble_reg, hex.value})
                    begin
                        phase_next  = PH_CR;
                        offset_next = offset_reg;
                        xor_next    = xor_reg;
                        nibble_next = nibble_reg;
                    end
                end
                PH_CR:
                begin
                    if (in_byte_reg == CH_CR)
                    begin
                        phase_next  = PH_LF;
                        offset_next = offset_reg;
                        xor_next    = xor_reg;
                        nibble_next = nibble_reg;
                    end
                end
                PH_LF:
                begin
                    hit = (in_byte_reg == CH_LF);
                end
                default:
                begin
                    phase_next = PH_SEARCH;
                end
            endcase
        end

        found_now  = found_reg || hit;
        found_next = found_now;

        // end of buffer drops the candidate and the found flag
        if (in_last_reg)
        begin
            phase_next  = PH_SEARCH;
            offset_next = '0;
            xor_next    = '0;
            nibble_next = '0;
            found_next  = 1'b0;
        end
    end

    // control and match state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_SEARCH;
            offset_reg    <= '0;
            xor_reg       <= '0;
            nibble_reg    <= '0;
            found_reg     <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (out_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (advance)
            begin
                phase_reg  <= phase_next;
                offset_reg <= offset_next;
                xor_reg    <= xor_next;
                nibble_reg <= nibble_next;
                found_reg  <= found_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
        if (advance)
        begin
            out_ok_reg    <= hit;
            out_found_reg <= found_now;
        end
    end

    // a completed sentence always reports found
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_ok_reg |-> out_found_reg)
        else $error("sentence pulse without found flag");

    // last beat of a buffer clears the found flag
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_last_reg |=> !found_reg && phase_reg == PH_SEARCH)
        else $error("buffer end did not clear match state");

    // search phase carries no partial checksum
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_SEARCH |-> offset_reg == '0 && xor_reg == '0)
        else $error("stale offset or checksum while searching");

    // offset never reaches the star limit
    assert property (@(posedge clk) disable iff (!rst_n)
        offset_reg < MAX_STAR_OFFSET)
        else $error("offset beyond star limit");

    // a byte moved out of the input register shows up as a result
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("result beat lost");

endmodule

`default_nettype wire

[sim/tb_top.sv]
`timescale 1ns / 100ps
// tb_top: self-checking bench for nmea_sentence_checker_unit
// drives byte beats through the stream ports and checks every flag beat against a
// local sentence tracker or a typed expectation; depends on nsc_pkg, unit rtl

module tb_top;

    import nsc_pkg::*;

    localparam int RAND_ITEMS    = 1600;
    localparam int WATCHDOG_MAX  = 5000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int N_SEGMENTS    = 4;

    // match phases of the sentence tracker
    typedef enum logic [2:0] {
        PH_SEARCH,
        PH_HEADER,
        PH_BODY,
        PH_HEX_HI,
        PH_HEX_LO,
        PH_CR,
        PH_LF
    } match_phase_t;

    // one byte beat, with an optional hand-typed expectation
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       typed;
        logic       ok;
        logic       found;
    } byte_beat_t;

    // flags carried by one result beat
    typedef struct packed {
        logic ok;
        logic found;
    } sentence_flags_t;

    typedef logic [7:0] byte_q_t[$];

    logic       clk;
    logic       rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;   // [7:0] byte_in
    logic       s_axis_tlast;   // buffer_end
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;   // [0] sentence_ok, [1] any_found

    byte_beat_t      pending_beats[$];
    byte_beat_t      offered_q[$];
    sentence_flags_t sentence_flags_q[$];

    int check_errors = 0;
    int idle_cycles;
    int send_idle_pct;
    int recv_stall_pct;

    // tracker state
    match_phase_t trk_phase;
    logic [6:0]   trk_offset;
    logic [7:0]   trk_xor;
    logic [3:0]   trk_high;
    logic         trk_found;

    nmea_sentence_checker_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // receiver back-pressure
    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // hex digit value with a valid bit on top
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [7:0] t;
        t = 8'h00;
        if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9)
        begin
            t = c - CH_DIGIT_0;
            return {1'b1, t[3:0]};
        end
        if (c >= CH_UPPER_A && c <= CH_UPPER_F)
        begin
            t = c - CH_UPPER_A + 8'd10;
            return {1'b1, t[3:0]};
        end
        if (c >= CH_LOWER_A && c <= CH_LOWER_F)
        begin
            t = c - CH_LOWER_A + 8'd10;
            return {1'b1, t[3:0]};
        end
        return 5'd0;
    endfunction

    // ascii digit for a nibble
    function automatic logic [7:0] hex_char(input logic [3:0] v, input bit lower);
        if (v < 4'd10)
            return CH_DIGIT_0 + v;
        return (lower ? CH_LOWER_A : CH_UPPER_A) + v - 8'd10;
    endfunction

    function automatic byte_q_t to_bytes(input string s);
        byte_q_t q;
        for (int i = 0; i < s.len(); i++)
            q.push_back(s[i]);
        return q;
    endfunction

    task automatic clear_match();
        trk_phase  = PH_SEARCH;
        trk_offset = 7'd0;
        trk_xor    = 8'd0;
        trk_high   = 4'd0;
    endtask

    // one byte through the sentence tracker
    task automatic predict_sentence_flags(input logic [7:0] c, input logic last,
                                          output logic ok, output logic found);
        logic [6:0] nxt;
        logic [4:0] hx;
        ok  = 1'b0;
        nxt = trk_offset + 7'd1;
        hx  = hex_nibble(c);
        if (c == CH_DOLLAR)
        begin
            clear_match();
            trk_phase = PH_HEADER;
        end
        else
        begin
            case (trk_phase)
                PH_HEADER:
                begin
                    if (nxt <= HEAD_LETTERS && c >= CH_UPPER_A && c <= CH_UPPER_Z)
                    begin
                        trk_offset = nxt;
                        trk_xor    = trk_xor ^ c;
                    end
                    else if (nxt == COMMA_OFFSET && c == CH_COMMA)
                    begin
                        trk_offset = nxt;
                        trk_xor    = trk_xor ^ c;
                        trk_phase  = PH_BODY;
                    end
                    else
                        clear_match();
                end
                PH_BODY:
                begin
                    if (c == CH_STAR)
                    begin
                        if (nxt <= MAX_STAR_OFFSET)
                            trk_phase = PH_HEX_HI;
                        else
                            clear_match();
                    end
                    else if (c >= CH_PRINT_LO && c <= CH_PRINT_HI && nxt < MAX_STAR_OFFSET)
                    begin
                        trk_offset = nxt;
                        trk_xor    = trk_xor ^ c;
                    end
                    else
                        clear_match();
                end
                PH_HEX_HI:
                begin
                    if (hx[4])
                    begin
                        trk_high  = hx[3:0];
                        trk_phase = PH_HEX_LO;
                    end
                    else
                        clear_match();
                end
                PH_HEX_LO:
                begin
                    if (hx[4] && trk_xor == {trk_high, hx[3:0]})
                        trk_phase = PH_CR;
                    else
                        clear_match();
                end
                PH_CR:
                begin
                    if (c == CH_CR)
                        trk_phase = PH_LF;
                    else
                        clear_match();
                end
                PH_LF:
                begin
                    if (c == CH_LF)
                    begin
                        ok        = 1'b1;
                        trk_found = 1'b1;
                    end
                    clear_match();
                end
                default:
                    clear_match();
            endcase
        end
        found = trk_found;
        // a sentence never spans two buffers
        if (last)
        begin
            clear_match();
            trk_found = 1'b0;
        end
    endtask

    task automatic add_beat(input logic [7:0] data, input logic last);
        pending_beats.push_back('{data, last, 1'b0, 1'b0, 1'b0});
    endtask

    task automatic add_typed(input logic [7:0] data, input logic last,
                             input logic ok, input logic found);
        pending_beats.push_back('{data, last, 1'b1, ok, found});
    endtask

    // queue a full sentence with its checksum, optionally wrong
    task automatic build_sentence(input byte_q_t hdr, input byte_q_t txt, input bit bad_sum,
                                  input bit lower_hi, input bit lower_lo, input bit last_on_lf);
        logic [7:0] sum;
        sum = 8'h00;
        add_beat(CH_DOLLAR, 1'b0);
        foreach (hdr[i])
        begin
            add_beat(hdr[i], 1'b0);
            sum = sum ^ hdr[i];
        end
        add_beat(CH_COMMA, 1'b0);
        sum = sum ^ CH_COMMA;
        foreach (txt[i])
        begin
            add_beat(txt[i], 1'b0);
            sum = sum ^ txt[i];
        end
        add_beat(CH_STAR, 1'b0);
        if (bad_sum)
            sum = sum ^ (8'h01 << $urandom_range(7));
        add_beat(hex_char(sum[7:4], lower_hi), 1'b0);
        add_beat(hex_char(sum[3:0], lower_lo), 1'b0);
        add_beat(CH_CR, 1'b0);
        add_beat(CH_LF, last_on_lf);
    endtask

    // random sentence, mostly well formed
    task automatic build_random_sentence(input int body_len);
        byte_q_t    hdr;
        byte_q_t    txt;
        logic [7:0] ch;
        int         start;
        int         len;
        int         fault;
        start = pending_beats.size();
        fault = $urandom_range(9);
        repeat (5)
            hdr.push_back(8'($urandom_range(CH_UPPER_Z, CH_UPPER_A)));
        repeat (body_len)
        begin
            do
                ch = 8'($urandom_range(CH_PRINT_HI, CH_PRINT_LO));
            while (ch == CH_DOLLAR || ch == CH_STAR);
            txt.push_back(ch);
        end
        build_sentence(hdr, txt, fault == 0, 1'($urandom_range(1)), 1'($urandom_range(1)),
                       $urandom_range(5) == 0);
        len = pending_beats.size() - start;
        // corrupt one byte or cut the tail
        if (fault == 1)
            pending_beats[start + $urandom_range(len - 1, 1)].data = 8'($urandom_range(255));
        else if (fault == 2)
            repeat ($urandom_range(len - 1, 1))
                void'(pending_beats.pop_back());
        for (int i = start; i < pending_beats.size(); i++)
            if ($urandom_range(49) == 0)
                pending_beats[i].last = 1'b1;
    endtask

    // offer one beat and hold it until taken
    task automatic send_beat(input byte_beat_t bb);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        offered_q.push_back(bb);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= bb.data;
        s_axis_tlast  <= bb.last;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic send_pending();
        while (pending_beats.size() > 0)
            send_beat(pending_beats.pop_front());
    endtask

    // hold off the sender until every flag beat is back
    task automatic wait_for_flags();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sentence_flags_q.size() != 0)
            @(posedge clk);
    endtask

    // scoreboard and watchdog
    always @(posedge clk)
    begin : scoreboard
        byte_beat_t      bb;
        sentence_flags_t want;
        sentence_flags_t pred;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                bb = offered_q.pop_front();
                predict_sentence_flags(s_axis_tdata, s_axis_tlast, pred.ok, pred.found);
                if (bb.typed)
                    sentence_flags_q.push_back('{bb.ok, bb.found});
                else
                    sentence_flags_q.push_back(pred);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (sentence_flags_q.size() == 0)
                begin
                    $error("unexpected result beat: sentence_ok %0b any_found %0b",
                           m_axis_tdata[0], m_axis_tdata[1]);
                    check_errors++;
                end
                else
                begin
                    want = sentence_flags_q.pop_front();
                    if (m_axis_tdata[0] !== want.ok)
                    begin
                        $error("sentence_ok: expected %0b, got %0b", want.ok, m_axis_tdata[0]);
                        check_errors++;
                    end
                    if (m_axis_tdata[1] !== want.found)
                    begin
                        $error("any_found: expected %0b, got %0b", want.found, m_axis_tdata[1]);
                        check_errors++;
                    end
                end
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_MAX)
            begin
                $display("tb_top: FAIL");
                $finish;
            end
        end
        else
        begin
            // tracker and watchdog follow the unit's reset
            clear_match();
            trk_found   = 1'b0;
            idle_cycles <= 0;
        end
    end

    // stimulus
    initial
    begin : stimulus
        int send_idle[N_SEGMENTS];
        int recv_stall[N_SEGMENTS];
        int items_sent;
        int seg;
        int kind;
        int before_cnt;
        send_idle  = '{0, 83, 0, 20};
        recv_stall = '{0, 0, 83, 20};
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        items_sent     = 0;
        seg            = 0;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'h00;
        s_axis_tlast  <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table: extremes, lowercase hex, buffer end, restart, bad checksum
        add_typed(8'h00, 1'b0, 1'b0, 1'b0);
        add_typed(8'hff, 1'b1, 1'b0, 1'b0);
        build_sentence(to_bytes("GPGGA"), to_bytes(" ~"), 1'b0, 1'b1, 1'b0, 1'b0);
        add_typed(CH_UPPER_A, 1'b1, 1'b0, 1'b1);
        add_typed(CH_DOLLAR, 1'b0, 1'b0, 1'b0);
        add_beat(CH_UPPER_Z, 1'b0);
        build_sentence(to_bytes("AZQRS"), to_bytes(""), 1'b1, 1'b0, 1'b0, 1'b0);
        add_beat(CH_PRINT_HI, 1'b0);
        send_pending();
        wait_for_flags();

        // random part in idling segments
        while (items_sent < RAND_ITEMS)
        begin
            if (items_sent * N_SEGMENTS / RAND_ITEMS != seg)
            begin
                seg = items_sent * N_SEGMENTS / RAND_ITEMS;
                wait_for_flags();
            end
            send_idle_pct  = send_idle[seg];
            recv_stall_pct = recv_stall[seg];
            kind = $urandom_range(99);
            before_cnt = pending_beats.size();
            if (kind < 75)
                build_random_sentence($urandom_range(10));
            else if (kind < 81)
                build_random_sentence($urandom_range(76, 72));
            else
                repeat ($urandom_range(6, 1))
                    add_beat(8'($urandom_range(255)), $urandom_range(15) == 0);
            items_sent += pending_beats.size() - before_cnt;
            send_pending();
        end

        // drain and report
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sentence_flags_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (check_errors == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
